// File: design/md5_pkg.sv
`default_nettype none
package md5_pkg;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS = 6'd56;
  localparam logic [5:0] LAST_POS = 6'h3F;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } md5_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } md5_out_t;

  // Additive constant table, one entry per step
  function automatic logic [31:0] md5_k(input logic [5:0] i);
    logic [31:0] k;
    begin
      case (i)
        6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
        6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
        6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
        6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
        6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
        6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
        6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
        6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
        6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
        6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
        6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
        6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
        6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
        6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
        6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
        6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
        6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
        6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
        6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
        6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
        6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
        6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
        6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
        6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
        6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
        6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
        6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
        6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
        6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
        6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
        6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
        6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
        default: k = 32'h0;
      endcase
      return k;
    end
  endfunction

  // Rotate amount per round and step-in-group
  function automatic logic [4:0] md5_rot(input logic [5:0] i);
    logic [4:0] r;
    begin
      case ({i[5:4], i[1:0]})
        4'd0: r = 5'd7;   4'd1: r = 5'd12; 4'd2: r = 5'd17; 4'd3: r = 5'd22;
        4'd4: r = 5'd5;   4'd5: r = 5'd9;  4'd6: r = 5'd14; 4'd7: r = 5'd20;
        4'd8: r = 5'd4;   4'd9: r = 5'd11; 4'd10: r = 5'd16; 4'd11: r = 5'd23;
        4'd12: r = 5'd6;  4'd13: r = 5'd10; 4'd14: r = 5'd15; 4'd15: r = 5'd21;
        default: r = 5'd0;
      endcase
      return r;
    end
  endfunction

endpackage
`default_nettype wire

// File: design/md5_stream_if.sv
`default_nettype none
interface md5_stream_if #(
  parameter type PAYLOAD_T = logic
);
  logic     valid;
  logic     ready;
  PAYLOAD_T payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: design/md5_round.sv
`default_nettype none
// One MD5 step: shared adder/rotate unit used 64 times per block
module md5_round (
  input  wire logic [5:0]  step,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  input  wire logic [31:0] c,
  input  wire logic [31:0] d,
  input  wire logic [31:0] m,
  output logic      [31:0] b_new,
  output logic      [3:0]  g
);
  import md5_pkg::*;

  logic [31:0] f;
  logic [31:0] sum;
  logic [4:0]  rot;
  logic [63:0] dbl;

  // Round function and message word index
  always_comb begin
    case (step[5:4])
      2'd0: begin
        f = (b & c) | (~b & d);
        g = step[3:0];
      end
      2'd1: begin
        f = (b & d) | (c & ~d);
        g = 4'((5 * step) + 1);
      end
      2'd2: begin
        f = b ^ c ^ d;
        g = 4'((3 * step) + 5);
      end
      default: begin
        f = c ^ (b | ~d);
        g = 4'(7 * step);
      end
    endcase
  end

  assign sum   = a + f + md5_k(step) + m;
  assign rot   = md5_rot(step);
  assign dbl   = {sum, sum} << rot;
  assign b_new = b + dbl[63:32];

endmodule
`default_nettype wire

// File: design/md5_message_digest_unit.sv
`default_nettype none
// MD5 digest unit: one byte per transfer.
// A byte that completes a block starts 64 compression steps on one shared
// step unit, followed by the hash update; no input is taken meanwhile.
// End of message: one or two padded blocks (padding stored byte by byte),
// then four digest words out, one per cycle while the receiver is ready.
// Synchronous reset loads the MD5 initial hash and clears the bit count.
module md5_message_digest_unit (
  input wire logic clk,
  input wire logic rst,
  md5_stream_if.sink   in_ch,
  md5_stream_if.source out_ch
);
  import md5_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PAD  = 3'd1;
  localparam logic [2:0] ST_COMP = 3'd2;
  localparam logic [2:0] ST_ADD  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]  state;
  logic [31:0] h [4];
  logic [31:0] blk [16];
  logic [63:0] bit_count;
  logic [63:0] len;
  logic [31:0] a, b, c, d;
  logic [5:0]  step;
  logic [5:0]  pos;
  logic        finishing;
  logic        pad_first;
  logic        len_block;
  logic [1:0]  oidx;

  logic [31:0] b_new;
  logic [3:0]  g;

  md5_round u_round (
    .step (step), .a (a), .b (b), .c (c), .d (d),
    .m (blk[g]), .b_new (b_new), .g (g)
  );

  // Byte to store while padding; length bytes only go into the final block
  logic [7:0] pad_byte;
  always_comb begin
    if (pad_first) begin
      pad_byte = PAD_BYTE;
    end else if (len_block && pos >= LEN_POS) begin
      pad_byte = len[{pos[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  assign in_ch.ready = (state == ST_IDLE);
  assign out_ch.valid = (state == ST_OUT);
  assign out_ch.payload.digest_word = h[oidx];
  assign out_ch.payload.word_index = oidx;
  assign out_ch.payload.last_word = (oidx == 2'd3);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      h[0] <= IV_A; h[1] <= IV_B; h[2] <= IV_C; h[3] <= IV_D;
      bit_count <= '0;
      pos <= '0;
      finishing <= 1'b0;
      pad_first <= 1'b0;
      len_block <= 1'b0;
      oidx <= '0;
      step <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_ch.valid) begin
            if (in_ch.payload.has_byte) begin
              blk[pos[5:2]][{pos[1:0], 3'b000} +: 8] <= in_ch.payload.data_byte;
              bit_count <= bit_count + 64'd8;
              pos <= pos + 6'd1;
            end
            finishing <= in_ch.payload.end_of_message;
            pad_first <= 1'b1;
            len <= bit_count + (in_ch.payload.has_byte ? 64'd8 : 64'd0);
            if (in_ch.payload.has_byte && pos == LAST_POS) begin
              state <= ST_COMP;
              step <= '0;
              a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3];
            end else if (in_ch.payload.end_of_message) begin
              state <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          // One padding byte per cycle; the 0x80 position decides if the
          // length fits in this block
          blk[pos[5:2]][{pos[1:0], 3'b000} +: 8] <= pad_byte;
          pad_first <= 1'b0;
          if (pad_first) begin
            len_block <= (pos < LEN_POS);
          end
          pos <= pos + 6'd1;
          if (pos == LAST_POS) begin
            state <= ST_COMP;
            step <= '0;
            a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3];
          end
        end
        ST_COMP: begin
          a <= d; d <= c; c <= b; b <= b_new;
          step <= step + 6'd1;
          if (step == LAST_POS) begin
            state <= ST_ADD;
          end
        end
        ST_ADD: begin
          h[0] <= h[0] + a; h[1] <= h[1] + b;
          h[2] <= h[2] + c; h[3] <= h[3] + d;
          if (!finishing) begin
            state <= ST_IDLE;
          end else if (!pad_first && len_block) begin
            state <= ST_OUT;
            oidx <= '0;
          end else begin
            // Next block carries the length (or the 0x80 is still pending)
            state <= ST_PAD;
            if (!pad_first) begin
              len_block <= 1'b1;
            end
          end
        end
        ST_OUT: begin
          if (out_ch.ready) begin
            oidx <= oidx + 2'd1;
            if (oidx == 2'd3) begin
              state <= ST_IDLE;
              finishing <= 1'b0;
              h[0] <= IV_A; h[1] <= IV_B; h[2] <= IV_C; h[3] <= IV_D;
              bit_count <= '0;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: sim/md5_message_digest_unit_test.sv
`timescale 1ns / 100ps
`default_nettype none
module md5_message_digest_unit_test;
  import md5_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  md5_stream_if #(.PAYLOAD_T(md5_in_t)) in_ch ();
  md5_stream_if #(.PAYLOAD_T(md5_out_t)) out_ch ();

  md5_message_digest_unit dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  always #10 clk = ~clk;

  // Predictor state
  logic [31:0] hash_state [4];
  logic [31:0] msg_block [16];
  logic [63:0] msg_bits;
  md5_out_t digest_queue [$];

  int error_count = 0;
  int digests_seen = 0;
  int bytes_sent = 0;
  int messages_sent = 0;
  bit sender_idle_on = 1'b1;
  bit sink_idle_on = 1'b1;
  bit sink_hold = 1'b0;
  int quiet_cycles = 0;

  localparam int WATCHDOG_LIMIT = 20000;

  function automatic logic [31:0] rotl_word(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // 64-step compression of the current block into the hash
  task automatic compress_block();
    logic [31:0] a, b, c, d, f, t;
    int g, rnd;
    int rot_tab [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
    logic [31:0] k_tab [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
    a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
    for (int i = 0; i < 64; i++) begin
      rnd = i >> 4;
      case (rnd)
        0: begin f = (b & c) | (~b & d); g = i; end
        1: begin f = (b & d) | (c & ~d); g = (5 * i + 1) & 15; end
        2: begin f = b ^ c ^ d; g = (3 * i + 5) & 15; end
        default: begin f = c ^ (b | ~d); g = (7 * i) & 15; end
      endcase
      t = d; d = c; c = b;
      b = b + rotl_word(a + f + k_tab[i] + msg_block[g], rot_tab[rnd * 4 + (i & 3)]);
      a = t;
    end
    hash_state[0] += a; hash_state[1] += b;
    hash_state[2] += c; hash_state[3] += d;
  endtask

  task automatic store_byte(input int pos, input logic [7:0] val);
    msg_block[pos >> 2][(pos & 3) * 8 +: 8] = val;
    if (pos == 63) compress_block();
  endtask

  task automatic restart_hash();
    hash_state[0] = IV_A; hash_state[1] = IV_B;
    hash_state[2] = IV_C; hash_state[3] = IV_D;
    msg_bits = '0;
  endtask

  // Predict the digest words caused by one accepted transfer
  task automatic predict_digest(input md5_in_t item);
    int pos;
    logic [63:0] len;
    md5_out_t res;
    if (item.has_byte) begin
      pos = int'(msg_bits[8:3]);
      msg_bits += 64'd8;
      store_byte(pos, item.data_byte);
    end
    if (item.end_of_message) begin
      len = msg_bits;
      pos = int'(msg_bits[8:3]);
      store_byte(pos, PAD_BYTE);
      pos = (pos + 1) & 63;
      while (pos != 56) begin
        store_byte(pos, 8'h00);
        pos = (pos + 1) & 63;
      end
      for (int k = 0; k < 8; k++) store_byte(56 + k, len[8 * k +: 8]);
      for (int k = 0; k < 4; k++) begin
        res.digest_word = hash_state[k];
        res.word_index = 2'(k);
        res.last_word = (k == 3);
        digest_queue.push_back(res);
      end
      restart_hash();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    error_count++;
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, exp_val, $realtime);
  endtask

  // Send one byte/end transfer, with random idling before it
  task automatic send_item(input logic [7:0] val, input bit has, input bit eom);
    md5_in_t item;
    int gap;
    if (sender_idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item.data_byte = val;
    item.has_byte = has;
    item.end_of_message = eom;
    in_ch.valid <= 1'b1;
    in_ch.payload <= item;
    do @(posedge clk); while (!in_ch.ready);
    predict_digest(item);
    if (has) bytes_sent++;
    if (eom) messages_sent++;
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++)
      send_item(8'($urandom), 1'b1, (i == len - 1) && $urandom_range(0, 1));
    // Either the last byte carried the end, or end with no byte follows
    if (len == 0 || !in_ch.payload.end_of_message)
      send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  // Stop offering right after the last transfer, then wait for all words
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (digest_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Directed: empty message, known vector "abc", idle items, extreme bytes
  task automatic test_directed();
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h55, 1'b1, 1'b0);
    send_item(8'haa, 1'b1, 1'b1);
    drain_results();
  endtask

  // Lengths around the block and padding boundaries
  task automatic test_boundaries();
    int lens [5] = '{55, 56, 63, 64, 65};
    foreach (lens[i]) send_message(lens[i]);
    drain_results();
  endtask

  // Receiver holds off while the sender keeps offering messages
  task automatic test_backpressure();
    sink_hold = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        sink_hold = 1'b0;
      end
      begin
        send_message(3);
        send_message(0);
        send_message(10);
      end
    join
    drain_results();
  endtask

  task automatic test_random(input int budget);
    int len;
    while (budget > 0) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 130) : $urandom_range(0, 20);
      if (len > budget) len = budget;
      if ($urandom_range(0, 7) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_message(len);
      budget -= len + 1;
    end
    drain_results();
  endtask

  // Receiver readiness with random stall bursts
  initial begin
    int burst;
    out_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      if (sink_hold) begin
        out_ch.ready <= 1'b0;
        @(posedge clk);
      end else if (sink_idle_on && $urandom_range(0, 3) == 0) begin
        burst = $urandom_range(1, 6);
        out_ch.ready <= 1'b0;
        repeat (burst) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    md5_out_t got, want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = out_ch.payload;
      if (digest_queue.size() == 0) begin
        report_mismatch("unexpected word", got.digest_word, 32'h0);
      end else begin
        want = digest_queue.pop_front();
        digests_seen++;
        if (got.digest_word !== want.digest_word)
          report_mismatch("digest_word", got.digest_word, want.digest_word);
        if (got.word_index !== want.word_index)
          report_mismatch("word_index", 32'(got.word_index), 32'(want.word_index));
        if (got.last_word !== want.last_word)
          report_mismatch("last_word", 32'(got.last_word), 32'(want.last_word));
      end
    end
  end

  // Watchdog: cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || rst)
      quiet_cycles <= 0;
    else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("md5_message_digest_unit verification failed");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    restart_hash();
    foreach (msg_block[i]) msg_block[i] = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_boundaries();
    test_backpressure();
    test_random(120);
    sender_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    test_random(50);
    $display("Covered %0d messages, %0d bytes, %0d digest words checked.",
             messages_sent, bytes_sent, digests_seen);
    if (error_count == 0 && digest_queue.size() == 0)
      $display("md5_message_digest_unit verification clean");
    else
      $display("md5_message_digest_unit verification failed");
    $finish;
  end
endmodule
`default_nettype wire
